// File: rtl/content_length_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the content-length deframer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONTENT_LENGTH_DEFRAMER_MACROS_SVH
`define CONTENT_LENGTH_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define CLD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication.
`define CLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// File: rtl/cld_pkg.sv
// ----------------------------------------------------------------------------
// Content-length deframer package
// Types, constants and the header key table shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cld_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int OUT_LENGTH_BITS = 32;
  localparam int KEY_LEN = 15;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef enum logic [2:0] {
    VP_KEY,
    VP_BLANK,
    VP_DIGITS,
    VP_DONE,
    VP_EMPTY
  } value_phase_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic is_body;
    logic hdr_end;
    logic frame_last;
    logic header_bad;
    logic [OUT_LENGTH_BITS-1:0] body_length;
  } cld_result_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0: ch = "c";
      4'd1: ch = "o";
      4'd2: ch = "n";
      4'd3: ch = "t";
      4'd4: ch = "e";
      4'd5: ch = "n";
      4'd6: ch = "t";
      4'd7: ch = "-";
      4'd8: ch = "l";
      4'd9: ch = "e";
      4'd10: ch = "n";
      4'd11: ch = "g";
      4'd12: ch = "t";
      4'd13: ch = "h";
      4'd14: ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/content_length_deframer.sv
// ----------------------------------------------------------------------------
// Content-length deframer
// Splits a byte stream into header and body messages framed by a
// content-length header field, tagging every byte with its role.
//
// The slave channel takes one raw byte per transaction on s_tdata. The master
// channel returns exactly one transaction per input byte: the byte itself, the
// parsed body length on a good header end, a body/header flag, header-end and
// bad-header flags in m_tuser, and m_tlast on the last byte of a good frame.
// A header whose length field is missing, has no digits or does not fit in
// LENGTH_BITS is reported bad on its final LF and only that header is dropped.
// m_tvalid rises in the cycle after input acceptance. Throughput is one
// byte per cycle while m_tready holds high, set by the single output register
// after the parse logic. When the receiver stalls, the output register holds
// its transaction and s_tready falls until m_tready returns. Reset clears all
// parse state: the block starts in the header search phase with no pending output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "content_length_deframer_macros.svh"

module content_length_deframer #(
  parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [39:0] m_tdata,       // [7:0] byte_out, [39:8] body_length
  output logic [2:0] m_tuser,        // [0] is_body, [1] hdr_end, [2] header_bad
  output logic m_tlast               // frame_last
);

  logic accept;
  cld_pkg::cld_result_t result;
  cld_pkg::cld_result_t out_reg;

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;

  cld_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .data_byte(s_tdata),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {out_reg.body_length, out_reg.byte_out};
  assign m_tuser = {out_reg.header_bad, out_reg.hdr_end, out_reg.is_body};
  assign m_tlast = out_reg.frame_last;

  `CLD_ASSERT_NOW(a_bad_at_end, m_tvalid && m_tuser[2], m_tuser[1])
  `CLD_ASSERT_NOW(a_end_not_body, m_tvalid && m_tuser[1], !m_tuser[0])
  `CLD_ASSERT_NOW(a_bad_no_frame, m_tvalid && m_tuser[2], !m_tlast && m_tdata[39:8] == 32'd0)
  `CLD_ASSERT_NEXT(a_accept_shows, s_tvalid && s_tready, m_tvalid)

endmodule

`default_nettype wire

// File: rtl/cld_core.sv
// ----------------------------------------------------------------------------
// Content-length deframer parse core
// Holds the header and body state and classifies one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_core #(
  parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire logic [7:0] data_byte,
  output cld_pkg::cld_result_t result
);

  logic in_body;
  logic in_body_next;
  logic [3:0] key_idx;
  logic [3:0] key_idx_next;
  cld_pkg::value_phase_t value_phase;
  cld_pkg::value_phase_t value_phase_next;
  logic [LENGTH_BITS-1:0] length_value;
  logic [LENGTH_BITS-1:0] length_value_next;
  logic overflow_seen;
  logic overflow_seen_next;
  logic [1:0] term_count;
  logic [1:0] term_count_next;
  logic [LENGTH_BITS-1:0] body_remaining;
  logic [LENGTH_BITS-1:0] body_remaining_next;

  logic [7:0] folded;
  logic is_digit;
  logic [LENGTH_BITS+3:0] product;
  logic product_ovf;
  logic term_hit;
  cld_pkg::value_phase_t vp_scan;
  logic [LENGTH_BITS-1:0] lv_scan;
  logic ovf_scan;
  logic [63:0] length_wide;

  always_comb begin
    folded = data_byte;
    if (data_byte inside {[8'h41:8'h5A]}) begin
      folded = data_byte | 8'h20;
    end
  end

  assign is_digit = data_byte inside {[8'h30:8'h39]};
  assign product = ({4'b0, length_value} << 3) + ({4'b0, length_value} << 1)
                 + (LENGTH_BITS+4)'(data_byte[3:0]);
  assign product_ovf = |product[LENGTH_BITS+3:LENGTH_BITS];
  assign term_hit = (data_byte == cld_pkg::CH_LF) && (term_count == 2'd3);
  assign length_wide = 64'(lv_scan);

  always_comb begin
    in_body_next = in_body;
    key_idx_next = key_idx;
    term_count_next = term_count;
    body_remaining_next = body_remaining;
    vp_scan = value_phase;
    lv_scan = length_value;
    ovf_scan = overflow_seen;

    value_phase_next = value_phase;
    length_value_next = length_value;
    overflow_seen_next = overflow_seen;

    result.byte_out = data_byte;
    result.is_body = 1'b0;
    result.hdr_end = 1'b0;
    result.frame_last = 1'b0;
    result.header_bad = 1'b0;
    result.body_length = '0;

    if (in_body) begin
      result.is_body = 1'b1;
      if (body_remaining != '0) begin
        body_remaining_next = body_remaining - 1'b1;
      end
      if (body_remaining <= LENGTH_BITS'(1)) begin
        result.frame_last = 1'b1;
        in_body_next = 1'b0;
      end
    end else begin
      case (value_phase)
        cld_pkg::VP_KEY: begin
          if (folded == cld_pkg::key_char(key_idx)) begin
            if (key_idx == 4'(cld_pkg::KEY_LEN - 1)) begin
              vp_scan = cld_pkg::VP_BLANK;
              key_idx_next = '0;
            end else begin
              key_idx_next = key_idx + 1'b1;
            end
          end else if (folded == cld_pkg::key_char(4'd0)) begin
            key_idx_next = 4'd1;
          end else begin
            key_idx_next = '0;
          end
        end
        cld_pkg::VP_BLANK: begin
          if (is_digit) begin
            vp_scan = cld_pkg::VP_DIGITS;
            if (!overflow_seen) begin
              if (product_ovf) begin
                ovf_scan = 1'b1;
              end else begin
                lv_scan = product[LENGTH_BITS-1:0];
              end
            end
          end else if (data_byte != cld_pkg::CH_SP && data_byte != cld_pkg::CH_TAB) begin
            vp_scan = cld_pkg::VP_EMPTY;
          end
        end
        cld_pkg::VP_DIGITS: begin
          if (is_digit) begin
            if (!overflow_seen) begin
              if (product_ovf) begin
                ovf_scan = 1'b1;
              end else begin
                lv_scan = product[LENGTH_BITS-1:0];
              end
            end
          end else begin
            vp_scan = cld_pkg::VP_DONE;
          end
        end
        default: begin
        end
      endcase

      if (data_byte == cld_pkg::CH_LF && term_count == 2'd1) begin
        term_count_next = 2'd2;
      end else if (data_byte == cld_pkg::CH_CR) begin
        term_count_next = (term_count == 2'd2) ? 2'd3 : 2'd1;
      end else begin
        term_count_next = 2'd0;
      end

      value_phase_next = vp_scan;
      length_value_next = lv_scan;
      overflow_seen_next = ovf_scan;

      if (term_hit) begin
        result.hdr_end = 1'b1;
        if (vp_scan == cld_pkg::VP_DONE && !ovf_scan) begin
          result.body_length = length_wide[cld_pkg::OUT_LENGTH_BITS-1:0];
          if (lv_scan == '0) begin
            result.frame_last = 1'b1;
          end else begin
            in_body_next = 1'b1;
            body_remaining_next = lv_scan;
          end
        end else begin
          result.header_bad = 1'b1;
        end
        key_idx_next = '0;
        value_phase_next = cld_pkg::VP_KEY;
        length_value_next = '0;
        overflow_seen_next = 1'b0;
        term_count_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body <= 1'b0;
      key_idx <= '0;
      value_phase <= cld_pkg::VP_KEY;
      length_value <= '0;
      overflow_seen <= 1'b0;
      term_count <= 2'd0;
      body_remaining <= '0;
    end else if (accept) begin
      in_body <= in_body_next;
      key_idx <= key_idx_next;
      value_phase <= value_phase_next;
      length_value <= length_value_next;
      overflow_seen <= overflow_seen_next;
      term_count <= term_count_next;
      body_remaining <= body_remaining_next;
    end
  end

endmodule

`default_nettype wire
